// ----- hw/rtl/seek_rate_position_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Seek rate position controller assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SEEK_RATE_POSITION_CONTROLLER_ASSERT_SVH
`define SEEK_RATE_POSITION_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define SRPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/srpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Seek rate position controller package
// Widths, codes, reset values and the configuration record.
// ----------------------------------------------------------------------------
package srpc_pkg;

   localparam int BLOCK_BYTES_DEF = 512;
   localparam int TIME_SCALE      = 100;

   localparam int OP_W       = 3;
   localparam int ELAPSED_W  = 16;
   localparam int POS_W      = 32;
   localparam int MODE_W     = 2;
   localparam int BYTES_W    = 32;
   localparam int DUR_W      = 24;
   localparam int SPEED_W    = 8;
   localparam int THR_W      = 16;
   localparam int ETIME_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   // 100 * (2^24 - 1) fits in 31 bits
   localparam int DENOM_W    = 31;
   localparam int PROD_W     = BYTES_W + ETIME_W;

   localparam logic [OP_W-1:0] OP_TICK = 3'd0;
   localparam logic [OP_W-1:0] OP_FWD  = 3'd1;
   localparam logic [OP_W-1:0] OP_REV  = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP = 3'd3;
   localparam logic [OP_W-1:0] OP_LOAD = 3'd4;

   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REV  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TRACK_BYTES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_DURATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEEK_SPEED     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd3;

   localparam logic [DUR_W-1:0]   DURATION_RST = 24'd1;
   localparam logic [SPEED_W-1:0] SPEED_RST    = 8'd10;

   typedef struct packed {
      logic [BYTES_W-1:0] track_bytes;
      logic [DUR_W-1:0]   track_duration;
      logic [SPEED_W-1:0] seek_speed;
      logic [THR_W-1:0]   move_threshold;
   } cfg_type;

endpackage

// ----- hw/rtl/seek_rate_position_controller.sv -----
// ----------------------------------------------------------------------------
// Seek rate position controller
// Fast forward / reverse seek state and byte position of a track player.
// ----------------------------------------------------------------------------
// Keys, stop, position loads and ticks arrive one request at a time and each
// gives exactly one response with the mode, byte position and the moved and
// hit_end flags. Keys, stop, loads, and ticks while idle or parked at a track
// end go from acceptance straight to the commit state. A seeking tick passes
// the multiply states and, if the scaled time is above the move threshold and
// the track length is not zero, both divisions: the byte count and the time
// it used come out of one restoring divider that produces one quotient bit
// per cycle over a 64-bit dividend, twice per tick. req_ready is low from
// acceptance until the response is in the output register; a new request is
// taken while that response waits for rsp_ready. Configuration is written
// through a plain write port, by the user only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module seek_rate_position_controller #(
   parameter int BLOCK_BYTES = srpc_pkg::BLOCK_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [srpc_pkg::OP_W-1:0]        req_op,
   input  logic [srpc_pkg::ELAPSED_W-1:0]   req_elapsed,
   input  logic [srpc_pkg::POS_W-1:0]       req_new_position,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [srpc_pkg::MODE_W-1:0]      rsp_mode,
   output logic [srpc_pkg::POS_W-1:0]       rsp_position,
   output logic                             rsp_moved,
   output logic                             rsp_hit_end,
   // configuration
   input  logic                             csr_we,
   input  logic [srpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import srpc_pkg::*;

   localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
   localparam int D2_W  = DENOM_W + BB_W;   // 100 * duration * block size
   localparam int AMT_W = POS_W + BB_W;     // low quotient word times block size

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;  // scaled time, time denominator
   localparam logic [2:0] ST_MUL2 = 3'd2;  // threshold check, bytes * time
   localparam logic [2:0] ST_MUL3 = 3'd3;  // start blocks division
   localparam logic [2:0] ST_DIV1 = 3'd4;  // blocks = prod / (denom * block)
   localparam logic [2:0] ST_AMT  = 3'd5;  // byte amount, start used-time division
   localparam logic [2:0] ST_DIV2 = 3'd6;  // used = (prod - rem) / track_bytes
   localparam logic [2:0] ST_FIN  = 3'd7;  // commit state, write response

   cfg_type cfg;

   logic [2:0]           state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [ETIME_W-1:0]   left_ff, left_in;

   // request and work registers
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]     newpos_ff, newpos_in;
   logic [ETIME_W-1:0]   etime_ff, etime_in;
   logic [DENOM_W-1:0]   denom_ff, denom_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [AMT_W-1:0]     amt_ff, amt_in;
   logic                 big_ff, big_in;
   logic [ETIME_W-1:0]   lo_new_ff, lo_new_in;

   // response registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]    rsp_mode_ff, rsp_mode_in;
   logic [POS_W-1:0]     rsp_position_ff, rsp_position_in;
   logic                 rsp_moved_ff, rsp_moved_in;
   logic                 rsp_hit_end_ff, rsp_hit_end_in;

   // shared divider
   logic                 div_start;
   logic [PROD_W-1:0]    div_dividend;
   logic [D2_W-1:0]      div_divisor;
   logic                 div_done;
   logic [PROD_W-1:0]    div_quotient;
   logic [D2_W-1:0]      div_remainder;

   // arithmetic helpers
   logic [SPEED_W+ELAPSED_W-1:0] scaled;
   logic [ETIME_W:0]     etime_sum;
   logic [DUR_W-1:0]     dur_eff;
   logic                 accept;
   logic                 out_free;
   logic                 seeking;
   logic [POS_W-1:0]     remain;
   logic [MODE_W-1:0]    mode_n;
   logic [POS_W-1:0]     pos_n;
   logic [ETIME_W-1:0]   left_n;
   logic                 hit_n;

   srpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srpc_div #(
      .DVD_W (PROD_W),
      .DSR_W (D2_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // a tick only does arithmetic when seeking and not parked at the end
   assign seeking = (req_op == OP_TICK) &&
                    (((mode_ff == MODE_FWD) && (pos_ff < cfg.track_bytes)) ||
                     ((mode_ff == MODE_REV) && (pos_ff != '0)));

   // divider operands: first blocks, then the time those blocks used
   // (denom * block * blocks equals prod minus the first remainder)
   assign div_start    = (state_ff == ST_MUL3) || (state_ff == ST_AMT);
   assign div_dividend = (state_ff == ST_MUL3) ? prod_ff
                                               : prod_ff - PROD_W'(div_remainder);
   assign div_divisor  = (state_ff == ST_MUL3) ? D2_W'(denom_ff) * D2_W'(BLOCK_BYTES)
                                               : D2_W'(cfg.track_bytes);

   // result of the request, evaluated in ST_FIN
   always_comb begin
      mode_n = mode_ff;
      pos_n  = pos_ff;
      left_n = left_ff;
      hit_n  = 1'b0;
      remain = cfg.track_bytes - pos_ff;
      case (op_ff)
         OP_TICK: begin
            if (mode_ff == MODE_FWD) begin
               if (pos_ff >= cfg.track_bytes) begin
                  mode_n = MODE_IDLE;
                  hit_n  = 1'b1;
               end else begin
                  left_n = lo_new_ff;
                  if (big_ff || (amt_ff >= AMT_W'(remain))) begin
                     pos_n  = cfg.track_bytes;
                     mode_n = MODE_IDLE;
                     hit_n  = 1'b1;
                  end else begin
                     pos_n = pos_ff + amt_ff[POS_W-1:0];
                  end
               end
            end else if (mode_ff == MODE_REV) begin
               if (pos_ff == '0) begin
                  mode_n = MODE_IDLE;
                  hit_n  = 1'b1;
               end else begin
                  left_n = lo_new_ff;
                  if (big_ff || (amt_ff >= AMT_W'(pos_ff))) begin
                     pos_n  = '0;
                     mode_n = MODE_IDLE;
                     hit_n  = 1'b1;
                  end else begin
                     pos_n = pos_ff - amt_ff[POS_W-1:0];
                  end
               end
            end
         end
         OP_FWD: begin
            if (pos_ff < cfg.track_bytes) begin
               mode_n = MODE_FWD;
               left_n = '0;
            end
         end
         OP_REV: begin
            if (pos_ff != '0) begin
               mode_n = MODE_REV;
               left_n = '0;
            end
         end
         OP_STOP: begin
            mode_n = MODE_IDLE;
         end
         OP_LOAD: begin
            pos_n = (newpos_ff > cfg.track_bytes) ? cfg.track_bytes : newpos_ff;
         end
         default: begin
            hit_n = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      pos_in          = pos_ff;
      left_in         = left_ff;
      op_in           = op_ff;
      elapsed_in      = elapsed_ff;
      newpos_in       = newpos_ff;
      etime_in        = etime_ff;
      denom_in        = denom_ff;
      prod_in         = prod_ff;
      amt_in          = amt_ff;
      big_in          = big_ff;
      lo_new_in       = lo_new_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_mode_in     = rsp_mode_ff;
      rsp_position_in = rsp_position_ff;
      rsp_moved_in    = rsp_moved_ff;
      rsp_hit_end_in  = rsp_hit_end_ff;

      scaled    = (SPEED_W+ELAPSED_W)'(cfg.seek_speed) *
                  (SPEED_W+ELAPSED_W)'(elapsed_ff);
      etime_sum = (ETIME_W+1)'(scaled) + (ETIME_W+1)'(left_ff);
      dur_eff   = (cfg.track_duration == '0) ? DUR_W'(1) : cfg.track_duration;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               elapsed_in = req_elapsed;
               newpos_in  = req_new_position;
               state_in   = seeking ? ST_MUL1 : ST_FIN;
            end
         end
         ST_MUL1: begin
            // scaled time saturates at 32 bits
            etime_in = etime_sum[ETIME_W] ? '1 : etime_sum[ETIME_W-1:0];
            denom_in = DENOM_W'(dur_eff) * DENOM_W'(TIME_SCALE);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if ((etime_ff <= ETIME_W'(cfg.move_threshold)) || (cfg.track_bytes == '0)) begin
               // no move: keep the whole time as leftover
               lo_new_in = etime_ff;
               amt_in    = '0;
               big_in    = 1'b0;
               state_in  = ST_FIN;
            end else begin
               prod_in  = PROD_W'(cfg.track_bytes) * PROD_W'(etime_ff);
               state_in = ST_MUL3;
            end
         end
         ST_MUL3: begin
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (div_done) begin
               state_in = ST_AMT;
            end
         end
         ST_AMT: begin
            // any quotient bit from bit 32 up means the move overshoots the track
            big_in   = |div_quotient[PROD_W-1:POS_W];
            amt_in   = AMT_W'(div_quotient[POS_W-1:0]) * AMT_W'(BLOCK_BYTES);
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_done) begin
               // used time never exceeds etime
               lo_new_in = etime_ff - div_quotient[ETIME_W-1:0];
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               mode_in         = mode_n;
               pos_in          = pos_n;
               left_in         = left_n;
               rsp_valid_in    = 1'b1;
               rsp_mode_in     = mode_n;
               rsp_position_in = pos_n;
               rsp_moved_in    = pos_n != pos_ff;
               rsp_hit_end_in  = hit_n;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         pos_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      elapsed_ff      <= elapsed_in;
      newpos_ff       <= newpos_in;
      etime_ff        <= etime_in;
      denom_ff        <= denom_in;
      prod_ff         <= prod_in;
      amt_ff          <= amt_in;
      big_ff          <= big_in;
      lo_new_ff       <= lo_new_in;
      rsp_mode_ff     <= rsp_mode_in;
      rsp_position_ff <= rsp_position_in;
      rsp_moved_ff    <= rsp_moved_in;
      rsp_hit_end_ff  <= rsp_hit_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mode     = rsp_mode_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_moved    = rsp_moved_ff;
   assign rsp_hit_end  = rsp_hit_end_ff;

endmodule

// ----- hw/rtl/srpc_csr.sv -----
// ----------------------------------------------------------------------------
// Seek rate position controller configuration registers
// Write-only register bank for track length, duration, speed and threshold.
// ----------------------------------------------------------------------------
module srpc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [srpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srpc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output srpc_pkg::cfg_type                cfg
);
   import srpc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TRACK_BYTES:    cfg_in.track_bytes    = csr_wdata[BYTES_W-1:0];
            REG_TRACK_DURATION: cfg_in.track_duration = csr_wdata[DUR_W-1:0];
            REG_SEEK_SPEED:     cfg_in.seek_speed     = csr_wdata[SPEED_W-1:0];
            REG_MOVE_THRESHOLD: cfg_in.move_threshold = csr_wdata[THR_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.track_bytes    <= '0;
         cfg_ff.track_duration <= DURATION_RST;
         cfg_ff.seek_speed     <= SPEED_RST;
         cfg_ff.move_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/srpc_div.sv -----
// ----------------------------------------------------------------------------
// Seek rate position controller divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module srpc_div #(
   parameter int DVD_W = 64,
   parameter int DSR_W = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DSR_W-1:0] remainder
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W:0]   trial;
   logic             fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[DVD_W-1]};
      fits     = trial >= {1'b0, dsr_ff};
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DVD_W);
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in   = fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         quo_in   = {quo_ff[DVD_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/srpc_port_check.sv -----
// ----------------------------------------------------------------------------
// Seek rate position controller port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "seek_rate_position_controller_assert.svh"

module srpc_port_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [srpc_pkg::MODE_W-1:0]      rsp_mode,
   input logic [srpc_pkg::POS_W-1:0]       rsp_position,
   input logic                             rsp_moved,
   input logic                             rsp_hit_end
);
   import srpc_pkg::*;

   // stalled response holds
   `SRPC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mode) && $stable(rsp_position) && $stable(rsp_moved) && $stable(rsp_hit_end), "stalled response changed")

   // reaching a track end always drops back to idle
   `SRPC_ASSERT_IMP(a_hit_idle, clock, reset, rsp_valid && rsp_hit_end, rsp_mode == MODE_IDLE, "hit_end with mode not idle")

   // one request in work at a time
   `SRPC_ASSERT_NXT(a_one_req, clock, reset, req_valid && req_ready, !req_ready, "ready right after accepting a request")

endmodule

bind seek_rate_position_controller srpc_port_check u_port_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_mode     (rsp_mode),
   .rsp_position (rsp_position),
   .rsp_moved    (rsp_moved),
   .rsp_hit_end  (rsp_hit_end)
);
